[hw/rtl/lpmrt_pkg.sv]
package lpmrt_pkg;

    localparam int TABLE_DEPTH = 128;

    localparam int ADDR_W = 32;
    localparam int LEN_W  = 6;
    localparam int PORT_W = 8;
    localparam int NH_W   = 32;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(32);

    // request kinds
    localparam logic [1:0] REQ_QUERY  = 2'd0;
    localparam logic [1:0] REQ_INSERT = 2'd1;
    localparam logic [1:0] REQ_DELETE = 2'd2;

    // result status codes
    localparam logic [1:0] STS_DONE      = 2'd0;
    localparam logic [1:0] STS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STS_FULL      = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0] prefix;
        logic [LEN_W-1:0]  len;
        logic [PORT_W-1:0] port;
        logic [NH_W-1:0]   next_hop;
    } t_entry;

    typedef struct packed {
        logic exact;   // same prefix and length
        logic better;  // longer than current best and matches under mask
    } t_cmp_res;

endpackage

[hw/rtl/lpm_route_table.sv]
// IPv4 longest-prefix-match route table, kept as a linear list in one memory.
// Slave channel s_axis_*: one request item per handshake; tuser carries the
// request kind (query, insert, delete), tdata the address, length, port and
// next hop. Master channel m_axis_*: exactly one result item per request;
// tuser carries the hit flag, tdata the next hop, port and status.
// The block takes one request at a time: s_axis_tready is high only while
// no request is in work. A request scans the stored entries through the
// single read port of the table memory, one entry per cycle; a delete that
// finds its entry then moves the last entry into the freed slot.
// The result goes to an output register; a new request is accepted while a
// result still waits there. If the receiver stalls, a finished second result
// holds inside the block until the register frees.
// Reset empties the table (entry count to zero) and clears both channels;
// the table memory itself is not cleared, since only entries below the count
// are ever read.
module lpm_route_table #(
    parameter int TABLE_DEPTH = lpmrt_pkg::TABLE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] dest_addr, [37:32] prefix_len, [45:38] in_port,
    // [77:46] in_next_hop, [79:78] zero
    input  logic [79:0] s_axis_tdata,
    // [1:0] req_type
    input  logic [1:0]  s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] out_next_hop, [39:32] out_port, [41:40] status, [47:42] zero
    output logic [47:0] m_axis_tdata,
    // [0] hit
    output logic [0:0]  m_axis_tuser
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_SCAN    = 5'b00010,
        ST_LAST_RD = 5'b00100,
        ST_LAST_MV = 5'b01000,
        ST_DONE    = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [1:0]                      r_req, n_req;
    logic [lpmrt_pkg::ADDR_W-1:0]    r_addr, n_addr;
    logic [lpmrt_pkg::LEN_W-1:0]     r_len, n_len;
    logic [lpmrt_pkg::PORT_W-1:0]    r_port_in, n_port_in;
    logic [lpmrt_pkg::NH_W-1:0]      r_nh_in, n_nh_in;

    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_issue, n_issue;
    logic          r_pend, n_pend;
    logic [AW-1:0] r_pend_idx, n_pend_idx;
    logic [AW-1:0] r_slot, n_slot;

    logic [lpmrt_pkg::LEN_W-1:0]  r_best, n_best;
    logic                         r_res_hit, n_res_hit;
    logic [lpmrt_pkg::NH_W-1:0]   r_res_nh, n_res_nh;
    logic [lpmrt_pkg::PORT_W-1:0] r_res_port, n_res_port;
    logic [1:0]                   r_res_sts, n_res_sts;

    logic        r_out_valid, n_out_valid;
    logic [47:0] r_out_data, n_out_data;
    logic        r_out_hit, n_out_hit;

    logic              wr_en, rd_en;
    logic [AW-1:0]     wr_addr, rd_addr;
    lpmrt_pkg::t_entry wr_data, rd_data;
    lpmrt_pkg::t_cmp_res cmp;

    logic                        issue;
    logic [CW-1:0]               last_cnt;
    logic [lpmrt_pkg::LEN_W-1:0] in_len;

    lpmrt_ram #(
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    lpmrt_cmp u_cmp (
        .i_entry    (rd_data),
        .i_key_addr (r_addr),
        .i_key_len  (r_len),
        .i_best_len (r_best),
        .o_res      (cmp)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_hit;

    assign issue    = (r_issue < r_count);
    assign last_cnt = r_count - 1'b1;
    assign in_len   = (s_axis_tdata[37:32] > lpmrt_pkg::MAX_LEN) ?
                      lpmrt_pkg::MAX_LEN : s_axis_tdata[37:32];

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_addr      = r_addr;
        n_len       = r_len;
        n_port_in   = r_port_in;
        n_nh_in     = r_nh_in;
        n_count     = r_count;
        n_issue     = r_issue;
        n_pend      = r_pend;
        n_pend_idx  = r_pend_idx;
        n_slot      = r_slot;
        n_best      = r_best;
        n_res_hit   = r_res_hit;
        n_res_nh    = r_res_nh;
        n_res_port  = r_res_port;
        n_res_sts   = r_res_sts;
        n_out_valid = r_out_valid & ~m_axis_tready;
        n_out_data  = r_out_data;
        n_out_hit   = r_out_hit;

        wr_en   = 1'b0;
        wr_addr = r_slot;
        wr_data = '{prefix: r_addr, len: r_len, port: r_port_in, next_hop: r_nh_in};
        rd_en   = 1'b0;
        rd_addr = r_issue[AW-1:0];

        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_req      = s_axis_tuser;
                    n_addr     = s_axis_tdata[31:0];
                    n_len      = in_len;
                    n_port_in  = s_axis_tdata[45:38];
                    n_nh_in    = s_axis_tdata[77:46];
                    n_issue    = '0;
                    n_pend     = 1'b0;
                    n_best     = '0;
                    n_res_hit  = 1'b0;
                    n_res_nh   = '0;
                    n_res_port = '0;
                    n_res_sts  = lpmrt_pkg::STS_DONE;
                    if (s_axis_tuser inside {lpmrt_pkg::REQ_QUERY, lpmrt_pkg::REQ_INSERT,
                                             lpmrt_pkg::REQ_DELETE}) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                // issue the next read while checking the entry read last cycle
                if (issue) begin
                    rd_en      = 1'b1;
                    n_issue    = r_issue + 1'b1;
                    n_pend     = 1'b1;
                    n_pend_idx = r_issue[AW-1:0];
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    if (r_req == lpmrt_pkg::REQ_QUERY) begin
                        if (cmp.better) begin
                            n_best     = rd_data.len;
                            n_res_nh   = rd_data.next_hop;
                            n_res_port = rd_data.port;
                        end
                    end else if (cmp.exact) begin
                        n_pend = 1'b0;
                        n_slot = r_pend_idx;
                        if (r_req == lpmrt_pkg::REQ_INSERT) begin
                            wr_en   = 1'b1;
                            wr_addr = r_pend_idx;
                            n_state = ST_DONE;
                        end else begin
                            n_state = ST_LAST_RD;
                        end
                    end
                end else if (!issue) begin
                    n_state = ST_DONE;
                    if (r_req == lpmrt_pkg::REQ_QUERY) begin
                        if (r_best != '0) begin
                            n_res_hit = 1'b1;
                        end else begin
                            n_res_sts = lpmrt_pkg::STS_NOT_FOUND;
                        end
                    end else if (r_req == lpmrt_pkg::REQ_INSERT) begin
                        if (r_count < CW'(TABLE_DEPTH)) begin
                            wr_en   = 1'b1;
                            wr_addr = r_count[AW-1:0];
                            n_count = r_count + 1'b1;
                        end else begin
                            n_res_sts = lpmrt_pkg::STS_FULL;
                        end
                    end else begin
                        n_res_sts = lpmrt_pkg::STS_NOT_FOUND;
                    end
                end
            end
            ST_LAST_RD: begin
                rd_en   = 1'b1;
                rd_addr = last_cnt[AW-1:0];
                n_state = ST_LAST_MV;
            end
            ST_LAST_MV: begin
                // move the last entry into the freed slot
                wr_en   = 1'b1;
                wr_addr = r_slot;
                wr_data = rd_data;
                n_count = last_cnt;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_hit   = r_res_hit;
                    n_out_data  = {6'b0, r_res_sts, r_res_port, r_res_nh};
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_issue     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_issue     <= n_issue;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_addr     <= n_addr;
        r_len      <= n_len;
        r_port_in  <= n_port_in;
        r_nh_in    <= n_nh_in;
        r_pend_idx <= n_pend_idx;
        r_slot     <= n_slot;
        r_best     <= n_best;
        r_res_hit  <= n_res_hit;
        r_res_nh   <= n_res_nh;
        r_res_port <= n_res_port;
        r_res_sts  <= n_res_sts;
        r_out_data <= n_out_data;
        r_out_hit  <= n_out_hit;
    end

endmodule

[hw/rtl/lpmrt_ram.sv]
module lpmrt_ram #(
    parameter int DEPTH = lpmrt_pkg::TABLE_DEPTH
) (
    input  logic                                        i_clk,
    input  logic                                        i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  lpmrt_pkg::t_entry                           i_wr_data,
    input  logic                                        i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output lpmrt_pkg::t_entry                           o_rd_data
);

    lpmrt_pkg::t_entry r_mem [DEPTH];
    lpmrt_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hw/rtl/lpmrt_cmp.sv]
module lpmrt_cmp (
    input  lpmrt_pkg::t_entry                 i_entry,
    input  logic [lpmrt_pkg::ADDR_W-1:0]      i_key_addr,
    input  logic [lpmrt_pkg::LEN_W-1:0]       i_key_len,
    input  logic [lpmrt_pkg::LEN_W-1:0]       i_best_len,
    output lpmrt_pkg::t_cmp_res               o_res
);

    logic [lpmrt_pkg::ADDR_W-1:0] mask;

    // network bit n lives at byte n/8, bit 7 - n%8
    always_comb begin
        mask = '0;
        for (int b = 0; b < lpmrt_pkg::ADDR_W / 8; b++) begin
            for (int j = 0; j < 8; j++) begin
                mask[b*8 + j] = (lpmrt_pkg::LEN_W'(b*8 + 7 - j) < i_entry.len);
            end
        end
    end

    always_comb begin
        o_res.exact  = (i_entry.prefix == i_key_addr) && (i_entry.len == i_key_len);
        o_res.better = (i_entry.len > i_best_len)
                    && ((i_entry.prefix & mask) == (i_key_addr & mask));
    end

endmodule

[bench/lpm_route_table_tb.sv]
`timescale 1ns / 100ps

module lpm_route_table_tb;

    localparam int DEPTH        = lpmrt_pkg::TABLE_DEPTH;
    localparam int RX_LONG_HOLD = 600;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE_WAIT  = DEPTH + 16;
    localparam int DIR_ROWS     = 24;

    localparam int ADDR_W = lpmrt_pkg::ADDR_W;
    localparam int LEN_W  = lpmrt_pkg::LEN_W;
    localparam int PORT_W = lpmrt_pkg::PORT_W;
    localparam int NH_W   = lpmrt_pkg::NH_W;

    localparam logic [LEN_W-1:0] MAX_LEN = lpmrt_pkg::MAX_LEN;

    localparam logic [1:0] REQ_QUERY  = lpmrt_pkg::REQ_QUERY;
    localparam logic [1:0] REQ_INSERT = lpmrt_pkg::REQ_INSERT;
    localparam logic [1:0] REQ_DELETE = lpmrt_pkg::REQ_DELETE;

    localparam logic [1:0] STS_DONE      = lpmrt_pkg::STS_DONE;
    localparam logic [1:0] STS_NOT_FOUND = lpmrt_pkg::STS_NOT_FOUND;
    localparam logic [1:0] STS_FULL      = lpmrt_pkg::STS_FULL;

    // request code the block must answer without changing the table
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef enum {MIX_TRAFFIC, FILL_TABLE, DRAIN_TABLE} t_traffic_mode;

    typedef struct packed {
        logic [1:0]        req;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;
        logic [PORT_W-1:0] port;
        logic [NH_W-1:0]   nh;
    } t_route_req;

    typedef struct packed {
        logic              hit;
        logic [NH_W-1:0]   nh;
        logic [PORT_W-1:0] port;
        logic [1:0]        status;
    } t_route_res;

    // one directed item; known marks a result typed in by hand
    typedef struct packed {
        logic [1:0]        req;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;
        logic [PORT_W-1:0] port;
        logic [NH_W-1:0]   nh;
        logic              known;
        logic              hit;
        logic [NH_W-1:0]   onh;
        logic [PORT_W-1:0] oport;
        logic [1:0]        status;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // [31:0] dest_addr, [37:32] prefix_len, [45:38] in_port, [77:46] in_next_hop
    logic [79:0] s_axis_tdata;
    // [1:0] req_type
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [31:0] out_next_hop, [39:32] out_port, [41:40] status
    logic [47:0] m_axis_tdata;
    // [0] hit
    logic [0:0]  m_axis_tuser;

    lpm_route_table u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // shadow route table
    logic [ADDR_W-1:0] rt_prefix [DEPTH];
    logic [LEN_W-1:0]  rt_len    [DEPTH];
    logic [PORT_W-1:0] rt_port   [DEPTH];
    logic [NH_W-1:0]   rt_nh     [DEPTH];
    int                rt_count = 0;

    t_route_res pending_results[$];

    bit idle_on      = 1'b1;
    bit rx_long_hold = 1'b0;
    int n_errors     = 0;
    int n_cycles     = 0;
    int n_sent       = 0;
    int n_hits       = 0;
    int n_misses     = 0;
    int n_replaced   = 0;
    int n_deleted    = 0;
    int n_dropped    = 0;

    t_dir_row dir_rows [DIR_ROWS] = '{
        '{REQ_QUERY,  32'h04030201, 0,  0,     0,            1, 0, 0, 0, STS_NOT_FOUND},
        '{REQ_DELETE, 32'h04030201, 24, 0,     0,            1, 0, 0, 0, STS_NOT_FOUND},
        '{REQ_UNUSED, 32'h0000000a, 8,  8'h11, 32'h1,        1, 0, 0, 0, STS_DONE},
        '{REQ_INSERT, 32'h0000000a, 8,  8'hff, 32'hffffffff, 1, 0, 0, 0, STS_DONE},
        '{REQ_INSERT, 32'h0000010a, 16, 8'h01, 32'h00000080, 1, 0, 0, 0, STS_DONE},
        '{REQ_QUERY,  32'h0302010a, 0,  0,     0,            0, 0, 0, 0, STS_DONE},
        '{REQ_QUERY,  32'h0000020a, 0,  0,     0,            0, 0, 0, 0, STS_DONE},
        '{REQ_INSERT, 32'h00000000, 0,  8'h55, 32'h000080ff, 1, 0, 0, 0, STS_DONE},
        '{REQ_QUERY,  32'h0100a8c0, 0,  0,     0,            1, 0, 0, 0, STS_NOT_FOUND},
        '{REQ_INSERT, 32'hffffffff, 63, 8'haa, 32'h12345678, 1, 0, 0, 0, STS_DONE},
        '{REQ_QUERY,  32'hffffffff, 0,  0,     0,            0, 0, 0, 0, STS_DONE},
        '{REQ_QUERY,  32'hfffffffe, 32, 0,     0,            0, 0, 0, 0, STS_DONE},
        '{REQ_INSERT, 32'hdeadbe0a, 8,  8'h33, 0,            1, 0, 0, 0, STS_DONE},
        '{REQ_QUERY,  32'h0909090a, 0,  0,     0,            0, 0, 0, 0, STS_DONE},
        '{REQ_INSERT, 32'h0000000a, 8,  8'h77, 32'h0100000a, 1, 0, 0, 0, STS_DONE},
        '{REQ_QUERY,  32'h0909090a, 0,  0,     0,            0, 0, 0, 0, STS_DONE},
        '{REQ_DELETE, 32'h0000000a, 8,  0,     0,            1, 0, 0, 0, STS_DONE},
        '{REQ_DELETE, 32'h0000000a, 8,  0,     0,            1, 0, 0, 0, STS_NOT_FOUND},
        '{REQ_QUERY,  32'h0909090a, 0,  0,     0,            0, 0, 0, 0, STS_DONE},
        '{REQ_DELETE, 32'hffffffff, 40, 0,     0,            1, 0, 0, 0, STS_DONE},
        '{REQ_DELETE, 32'hdeadbe0a, 7,  0,     0,            1, 0, 0, 0, STS_NOT_FOUND},
        '{REQ_UNUSED, 32'hffffffff, 63, 8'hff, 32'hffffffff, 1, 0, 0, 0, STS_DONE},
        '{REQ_INSERT, 32'h00000080, 1,  8'h80, 32'h00000080, 1, 0, 0, 0, STS_DONE},
        '{REQ_QUERY,  32'h000000ff, 0,  0,     0,            0, 0, 0, 0, STS_DONE}
    };

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // mask of the first plen bits in network order, bit 7 of byte 0 first
    function automatic logic [ADDR_W-1:0] net_order_mask(input int unsigned plen);
        logic [ADDR_W-1:0] m;
        m = '0;
        for (int i = 0; i < int'(plen) && i < 32; i++)
            m[(i / 8) * 8 + 7 - (i % 8)] = 1'b1;
        return m;
    endfunction

    function automatic int find_route(input logic [ADDR_W-1:0] addr,
                                      input logic [LEN_W-1:0] plen);
        for (int i = 0; i < rt_count; i++)
            if (rt_prefix[i] == addr && rt_len[i] == plen)
                return i;
        return -1;
    endfunction

    // apply one request to the shadow table and return its result
    function automatic t_route_res route_apply(input t_route_req rq);
        t_route_res        r;
        logic [LEN_W-1:0]  plen;
        logic [ADDR_W-1:0] m;
        int unsigned       best;
        int                slot;
        r = '0;
        plen = (rq.len > MAX_LEN) ? MAX_LEN : rq.len;
        case (rq.req)
            REQ_QUERY: begin
                best = 0;
                for (int i = 0; i < rt_count; i++) begin
                    m = net_order_mask(rt_len[i]);
                    if (rt_len[i] > best && (rt_prefix[i] & m) == (rq.addr & m)) begin
                        best   = rt_len[i];
                        r.nh   = rt_nh[i];
                        r.port = rt_port[i];
                    end
                end
                if (best != 0) begin
                    r.hit = 1'b1;
                    n_hits++;
                end else begin
                    r.status = STS_NOT_FOUND;
                    n_misses++;
                end
            end
            REQ_INSERT: begin
                slot = find_route(rq.addr, plen);
                if (slot >= 0) begin
                    rt_port[slot] = rq.port;
                    rt_nh[slot]   = rq.nh;
                    n_replaced++;
                end else if (rt_count < DEPTH) begin
                    rt_prefix[rt_count] = rq.addr;
                    rt_len[rt_count]    = plen;
                    rt_port[rt_count]   = rq.port;
                    rt_nh[rt_count]     = rq.nh;
                    rt_count++;
                end else begin
                    r.status = STS_FULL;
                    n_dropped++;
                end
            end
            REQ_DELETE: begin
                slot = find_route(rq.addr, plen);
                if (slot >= 0) begin
                    // move the last entry into the freed slot
                    rt_prefix[slot] = rt_prefix[rt_count - 1];
                    rt_len[slot]    = rt_len[rt_count - 1];
                    rt_port[slot]   = rt_port[rt_count - 1];
                    rt_nh[slot]     = rt_nh[rt_count - 1];
                    rt_count--;
                    n_deleted++;
                end else begin
                    r.status = STS_NOT_FOUND;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] random_addr();
        logic [ADDR_W-1:0] a;
        a = $urandom;
        // crowd most addresses into a few nested ranges so prefixes overlap
        case ($urandom_range(0, 3))
            1: begin
                a[7:0]  = 8'h0a;
                a[15:8] = 8'($urandom_range(0, 3));
            end
            2: a[15:0] = 16'ha8c0;
            3: a[7:0]  = 8'hac;
            default: ;
        endcase
        return a;
    endfunction

    function automatic logic [LEN_W-1:0] random_len();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return LEN_W'($urandom_range(33, 63));
            default: return LEN_W'($urandom_range(1, 32));
        endcase
    endfunction

    // reuse the key of a stored route; caller makes sure the table is not empty
    function automatic void copy_stored_key(inout t_route_req rq);
        int slot;
        slot    = $urandom_range(0, rt_count - 1);
        rq.addr = rt_prefix[slot];
        rq.len  = rt_len[slot];
        // a length above 32 names the same full-length key
        if (rq.len == MAX_LEN && $urandom_range(0, 1) == 1)
            rq.len = LEN_W'($urandom_range(33, 63));
    endfunction

    function automatic t_route_req random_request(input t_traffic_mode mode);
        t_route_req        rq;
        logic [ADDR_W-1:0] m;
        int unsigned       pick;
        int                slot;
        rq.addr = random_addr();
        rq.len  = random_len();
        rq.port = PORT_W'($urandom);
        rq.nh   = ($urandom_range(0, 7) == 0) ? '0 : NH_W'($urandom);
        pick    = $urandom_range(0, 99);
        case (mode)
            FILL_TABLE:
                rq.req = (pick < 85) ? REQ_INSERT : (pick < 97) ? REQ_QUERY : REQ_DELETE;
            DRAIN_TABLE:
                rq.req = (pick < 65) ? REQ_DELETE : (pick < 90) ? REQ_QUERY : REQ_INSERT;
            default:
                rq.req = (pick < 45) ? REQ_QUERY : (pick < 80) ? REQ_INSERT :
                         (pick < 97) ? REQ_DELETE : REQ_UNUSED;
        endcase
        case (rq.req)
            REQ_QUERY:
                if (rt_count > 0 && $urandom_range(0, 9) < 7) begin
                    slot    = $urandom_range(0, rt_count - 1);
                    m       = net_order_mask(rt_len[slot]);
                    rq.addr = (rt_prefix[slot] & m) | (ADDR_W'($urandom) & ~m);
                end
            REQ_INSERT:
                if (mode == FILL_TABLE) begin
                    rq.addr = $urandom;
                    rq.len  = LEN_W'($urandom_range(1, 32));
                end else if (rt_count > 0 && $urandom_range(0, 3) == 0) begin
                    copy_stored_key(rq);
                end
            REQ_DELETE:
                if (rt_count > 0 && $urandom_range(0, 9) < 7)
                    copy_stored_key(rq);
            default: ;
        endcase
        return rq;
    endfunction

    task automatic offer_request(input t_route_req rq, input logic known,
                                 input t_route_res known_res);
        t_route_res predicted;
        int         gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            gap = $urandom_range(1, 15);
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, rq.nh, rq.port, rq.len, rq.addr};
        s_axis_tuser  <= rq.req;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        predicted = route_apply(rq);
        pending_results.push_back(known ? known_res : predicted);
        n_sent++;
    endtask

    task automatic run_traffic(input t_traffic_mode mode, input int count);
        for (int k = 0; k < count; k++)
            offer_request(random_request(mode), 1'b0, '0);
    endtask

    task automatic wait_results_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    initial begin : stimulus
        t_route_req rq;
        t_route_res res;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            rq  = '{dir_rows[k].req, dir_rows[k].addr, dir_rows[k].len,
                    dir_rows[k].port, dir_rows[k].nh};
            res = '{dir_rows[k].hit, dir_rows[k].onh, dir_rows[k].oport,
                    dir_rows[k].status};
            offer_request(rq, dir_rows[k].known, res);
        end

        run_traffic(MIX_TRAFFIC, 450);
        // hold the sender until the block has answered everything
        s_axis_tvalid <= 1'b0;
        wait_results_drained();
        run_traffic(FILL_TABLE, 170);
        rx_long_hold = 1'b1;
        run_traffic(MIX_TRAFFIC, 300);
        run_traffic(DRAIN_TABLE, 180);
        idle_on = 1'b0;
        run_traffic(MIX_TRAFFIC, 280);
        s_axis_tvalid <= 1'b0;

        wait_results_drained();
        repeat (SETTLE_WAIT) @(posedge i_clk);
        $display("ran %0d requests: %0d query hits, %0d misses, %0d routes replaced,",
                 n_sent, n_hits, n_misses, n_replaced);
        $display("%0d routes deleted, %0d inserts dropped on a full table",
                 n_deleted, n_dropped);
        if (n_errors == 0) begin
            $display("lpm_route_table_tb passed");
        end else begin
            $display("lpm_route_table_tb failed");
        end
        $finish;
    end

    // receiver: random stall bursts, plus one long hold-off on request
    initial begin : receiver
        int n;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_long_hold) begin
                m_axis_tready <= 1'b0;
                repeat (RX_LONG_HOLD - 1) @(posedge i_clk);
                rx_long_hold = 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                n = $urandom_range(1, 15);
                repeat (n - 1) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            n_errors++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_route_res want;
        if (i_rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result item: expected none, actual %h/%h",
                         $time, m_axis_tuser, m_axis_tdata);
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("hit", 32'(want.hit), 32'(m_axis_tuser[0]));
                check_field("next hop", want.nh, m_axis_tdata[31:0]);
                check_field("port", 32'(want.port), 32'(m_axis_tdata[39:32]));
                check_field("status", 32'(want.status), 32'(m_axis_tdata[41:40]));
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d results outstanding",
                     $time, pending_results.size());
            $display("lpm_route_table_tb failed");
            $finish;
        end
    end

endmodule
